// ----- hw/rtl/relay_pulse_burst_timer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Relay burst timer assertion macros
// Shared concurrent assertion forms for the relay burst timer RTL.
// ----------------------------------------------------------------------------
`ifndef RELAY_PULSE_BURST_TIMER_UNIT_ASSERT_SVH
`define RELAY_PULSE_BURST_TIMER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset
`define RPBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define RPBT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rpbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Relay burst timer package
// Sizes, command and status codes, and helpers shared by the timer RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package rpbt_pkg;

	// Number of relay channels (1..4) and width of the phase counters (8..32)
	localparam int CHANNELS  = 4;
	localparam int TIME_BITS = 16;

	// Fixed field widths
	localparam int NUM_W   = 3;
	localparam int DUR_W   = 16;
	localparam int REP_W   = 16;
	localparam int MASK_W  = 4;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF >> (32 - TIME_BITS);

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_NUM = 2'd1,
		ST_BUSY    = 2'd2
	} status_t;

	// Per-channel operation for one transaction
	typedef struct packed {
		logic start;
		logic toggle;
		logic tick;
	} chan_op_t;

	// Status view of one channel, used for both current and next state
	typedef struct packed {
		logic energized;
		logic busy;
		logic remembered;
	} chan_stat_t;

	// Clamp a 16-bit duration to the phase counter range
	function automatic logic [TIME_BITS-1:0] sat_time(input logic [DUR_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > TIME_MAX) ? TIME_BITS'(TIME_MAX) : TIME_BITS'(w);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rpbt_chan.sv -----
// ----------------------------------------------------------------------------
// Relay burst timer channel
// State and burst sequencing of one relay channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpbt_chan
	import rpbt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chan_op_t         op,
	input  wire logic [DUR_W-1:0] up_ticks,
	input  wire logic [DUR_W-1:0] down_ticks,
	input  wire logic [REP_W-1:0] repeat_count,
	output chan_stat_t            cur,
	output chan_stat_t            nxt
);

	`include "relay_pulse_burst_timer_unit_assert.svh"

	logic                 relay_q, rem_q, busy_q, on_q;
	logic [TIME_BITS-1:0] phase_q, on_dur_q, off_dur_q;
	logic [REP_W-1:0]     cycles_q;

	logic                 relay_d, rem_d, busy_d, on_d;
	logic [TIME_BITS-1:0] phase_d;
	logic [REP_W-1:0]     cycles_d, cycles_dec;
	logic                 load_dur;

	assign cycles_dec = (cycles_q != '0) ? cycles_q - REP_W'(1) : cycles_q;
	assign load_dur   = op.start && !busy_q && (repeat_count != '0);

	// Next channel state
	always_comb begin
		relay_d  = relay_q;
		rem_d    = rem_q;
		busy_d   = busy_q;
		on_d     = on_q;
		phase_d  = phase_q;
		cycles_d = cycles_q;
		priority if (load_dur) begin
			relay_d  = 1'b1;
			busy_d   = 1'b1;
			on_d     = 1'b1;
			phase_d  = sat_time(up_ticks);
			cycles_d = repeat_count;
		end else if (op.toggle) begin
			rem_d   = !rem_q;
			relay_d = !rem_q;
		end else if (op.tick && busy_q) begin
			priority if (phase_q > TIME_BITS'(1)) begin
				phase_d = phase_q - TIME_BITS'(1);
			end else if (on_q) begin
				relay_d = 1'b0;
				on_d    = 1'b0;
				phase_d = off_dur_q;
			end else if (cycles_dec == '0) begin
				cycles_d = cycles_dec;
				busy_d   = 1'b0;
				phase_d  = '0;
			end else begin
				cycles_d = cycles_dec;
				relay_d  = 1'b1;
				on_d     = 1'b1;
				phase_d  = on_dur_q;
			end
		end else begin
			// nothing for this channel: hold
			phase_d = phase_q;
		end
	end

	// Control and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q  <= 1'b0;
			rem_q    <= 1'b0;
			busy_q   <= 1'b0;
			on_q     <= 1'b0;
			phase_q  <= '0;
			cycles_q <= '0;
		end else begin
			relay_q  <= relay_d;
			rem_q    <= rem_d;
			busy_q   <= busy_d;
			on_q     <= on_d;
			phase_q  <= phase_d;
			cycles_q <= cycles_d;
		end
	end

	// Burst durations, only read while busy
	always_ff @(posedge clk) begin
		if (load_dur) begin
			on_dur_q  <= sat_time(up_ticks);
			off_dur_q <= sat_time(down_ticks);
		end
	end

	assign cur = '{energized: relay_q, busy: busy_q, remembered: rem_q};
	assign nxt = '{energized: relay_d, busy: busy_d, remembered: rem_d};

	`RPBT_ASSERT(a_busy_has_cycles, busy_q |-> (cycles_q != '0), "busy channel with no cycles left")
	`RPBT_ASSERT(a_idle_not_on, !busy_q |-> !on_q, "idle channel still in on phase")
	`RPBT_ASSERT(a_start_turns_on, load_dur |=> (busy_q && relay_q && on_q),
		"accepted start did not begin a burst")

endmodule

`default_nettype wire

// ----- hw/rtl/relay_pulse_burst_timer_unit.sv -----
// ----------------------------------------------------------------------------
// Relay burst timer unit
// Multi-channel relay driver with per-channel on/off burst timers.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_* stream: s_tuser carries the command (start,
//   toggle, tick), s_tdata the relay number, up/down durations and repeat
//   count. Every command yields one response on the m_* stream with status,
//   driven pin levels, busy mask and the new toggle state.
//   The command is held in the input register, and the channel update is
//   captured in the result register, which drives the response.
//   Throughput is one command per cycle while m_tready stays high; every
//   channel updates in parallel in the single update stage.
//   The polarity bit is written through cfg_we/cfg_wdata; the user must write
//   it only while no command is in flight, which the block does not enforce.
//   Reset clears all channels (relays off, idle) and sets active-low
//   polarity. When m_tready is low the response holds, one more command is
//   taken into the input register, and then s_tready drops until the
//   receiver takes the response.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_pulse_burst_timer_unit
	import rpbt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,   // active_low
	// Command stream
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [55:0] s_tdata,     // chan_num[2:0], up_ticks[18:3],
	                                      // down_ticks[34:19], repeat_count[50:35]
	input  wire logic [1:0]  s_tuser,     // command[1:0]
	// Response stream
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata      // status[1:0], pin_levels[5:2],
	                                      // busy_mask[9:6], toggle_state[10]
);

	`include "relay_pulse_burst_timer_unit_assert.svh"

	logic active_low_q;

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DUR_W-1:0] up_s1, down_s1;
	logic [REP_W-1:0] rep_s1;

	logic              valid_s2;
	status_t           status_s2;
	logic [MASK_W-1:0] pins_s2, busy_s2;
	logic              tog_s2;

	logic                load_s2, fire_s1;
	logic [CHANNELS-1:0] sel, busy_cur, relay_nxt, busy_nxt, rem_nxt;
	logic                num_ok, sel_busy;
	status_t             status_d;
	logic [MASK_W-1:0]   pins_d, busy_d;
	logic                tog_d;

	// Handshake: the input register drains whenever the result slot is free
	assign load_s2  = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;

	// Polarity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= 1'b1;
		end else if (cfg_we) begin
			active_low_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			num_s1  <= s_tdata[2:0];
			up_s1   <= s_tdata[18:3];
			down_s1 <= s_tdata[34:19];
			rep_s1  <= s_tdata[50:35];
		end
	end

	// Channels
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		chan_op_t   op;
		chan_stat_t cur, nxt;

		assign sel[c]    = (num_s1 == NUM_W'(c + 1));
		assign op.start  = fire_s1 && (cmd_s1 == CMD_START) && sel[c];
		assign op.toggle = fire_s1 && (cmd_s1 == CMD_TOGGLE) && sel[c];
		assign op.tick   = fire_s1 && (cmd_s1 == CMD_TICK);

		rpbt_chan u_chan (
			.clk          (clk),
			.arst_n       (arst_n),
			.op           (op),
			.up_ticks     (up_s1),
			.down_ticks   (down_s1),
			.repeat_count (rep_s1),
			.cur          (cur),
			.nxt          (nxt)
		);

		assign busy_cur[c]  = cur.busy;
		assign relay_nxt[c] = nxt.energized;
		assign busy_nxt[c]  = nxt.busy;
		assign rem_nxt[c]   = nxt.remembered;
	end

	assign num_ok   = |sel;
	assign sel_busy = |(sel & busy_cur);

	// Response fields
	always_comb begin
		status_d = ST_OK;
		tog_d    = 1'b0;
		pins_d   = '0;
		busy_d   = '0;
		unique case (cmd_s1)
			CMD_START: begin
				priority if (!num_ok) begin
					status_d = ST_BAD_NUM;
				end else if (sel_busy) begin
					status_d = ST_BUSY;
				end else begin
					status_d = ST_OK;
				end
			end
			CMD_TOGGLE: begin
				if (!num_ok) begin
					status_d = ST_BAD_NUM;
				end else begin
					tog_d = |(sel & rem_nxt);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		for (int i = 0; i < CHANNELS; i++) begin
			pins_d[i] = relay_nxt[i] ^ active_low_q;
			busy_d[i] = busy_nxt[i];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_d;
			pins_s2   <= pins_d;
			busy_s2   <= busy_d;
			tog_s2    <= tog_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, tog_s2, busy_s2, pins_s2, status_s2};

	`RPBT_ASSERT(a_toggle_ok, (valid_s2 && tog_s2) |-> (status_s2 == ST_OK),
		"toggle state reported on a refused command")
	`RPBT_ASSERT(a_busy_skip_shows_busy, (valid_s2 && status_s2 == ST_BUSY) |-> (busy_s2 != '0),
		"busy skip reported with no busy channel")
	`RPBT_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!valid_s1 && !valid_s2),
		"pipeline holds data during reset")

endmodule

`default_nettype wire
